// ===== design/pwf_pkg.sv =====
package pwf_pkg;

   localparam int WORD_WIDTH = 64;
   localparam int TAG_WIDTH = 16;
   localparam int STRIP_WIDTH = WORD_WIDTH - TAG_WIDTH;
   localparam int MASK_WIDTH = 3;
   localparam int SLOT_WIDTH = 3;
   localparam int SLOT_CODES = 1 << SLOT_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int REGION_SLOTS_DEFAULT = 8;

   localparam logic [WORD_WIDTH-1:0] MIN_POINTER_RESET = 64'h0000_0045_0000_0000;
   localparam logic [WORD_WIDTH-1:0] MAX_POINTER_RESET = 64'h0000_007F_FFFF_FFFF;
   localparam logic [TAG_WIDTH-1:0] TAG_VALUE_RESET = 16'hB400;
   localparam logic [MASK_WIDTH-1:0] ALIGN_MASK_RESET = 3'd3;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_POINTER = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_POINTER = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAG_VALUE = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALIGN_MASK = 2'd3;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] min_pointer;
      logic [WORD_WIDTH-1:0] max_pointer;
      logic [TAG_WIDTH-1:0]  tag_value;
      logic [MASK_WIDTH-1:0] align_mask;
   } filter_cfg_type;

   typedef struct packed {
      logic                  en;
      logic [SLOT_WIDTH-1:0] slot;
      logic [WORD_WIDTH-1:0] start;
      logic [WORD_WIDTH-1:0] limit;
      logic                  enable;
   } region_write_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_WIDTH-1:0] slot;
      logic [WORD_WIDTH-1:0] offset;
   } region_hit_type;

endpackage

// ===== design/pwf_classify.sv =====
module pwf_classify (
   input  pwf_pkg::filter_cfg_type            cfg,
   input  logic [pwf_pkg::WORD_WIDTH-1:0]     word_value,
   output logic                               is_pointer,
   output logic [pwf_pkg::WORD_WIDTH-1:0]     stripped
);
   import pwf_pkg::*;

   always_comb begin
      if (word_value[WORD_WIDTH-1 -: TAG_WIDTH] == cfg.tag_value) begin
         stripped = {{TAG_WIDTH{1'b0}}, word_value[STRIP_WIDTH-1:0]};
      end else begin
         stripped = word_value;
      end
   end

   // inverted bounds fail at least one compare for every value
   assign is_pointer = (stripped >= cfg.min_pointer) && (stripped <= cfg.max_pointer) &&
                       ((stripped[MASK_WIDTH-1:0] & cfg.align_mask) == '0);

endmodule

// ===== design/pwf_region_table.sv =====
module pwf_region_table #(
   parameter int DEPTH = pwf_pkg::SLOT_CODES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pwf_pkg::region_write_type         wr,
   input  logic [pwf_pkg::WORD_WIDTH-1:0]    lookup_address,
   output pwf_pkg::region_hit_type           result
);
   import pwf_pkg::*;

   logic [WORD_WIDTH-1:0] start_ff [DEPTH];
   logic [WORD_WIDTH-1:0] limit_ff [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [DEPTH-1:0]      valid_in;
   logic [DEPTH-1:0]      match;
   logic [WORD_WIDTH-1:0] diff [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      logic sel;
      assign sel = wr.en && (wr.slot == SLOT_WIDTH'(g));

      always_ff @(posedge clock) begin
         if (sel) begin
            start_ff[g] <= wr.start;
            limit_ff[g] <= wr.limit;
         end
      end

      assign valid_in[g] = sel ? wr.enable : valid_ff[g];

      // empty or inverted regions never match
      assign match[g] = valid_ff[g] && (lookup_address >= start_ff[g]) &&
                        (lookup_address < limit_ff[g]);
      assign diff[g] = lookup_address - start_ff[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // lowest matching slot wins
   always_comb begin
      result = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            result.hit = 1'b1;
            result.slot = SLOT_WIDTH'(i);
            result.offset = diff[i];
         end
      end
   end

endmodule

// ===== design/pointer_word_filter_core.sv =====
// Pointer word filter. Each request beat either scans one 64-bit memory word
// (req_op = 0) or loads one static region slot (req_op = 1), and gives exactly one
// response beat. A scan strips the tag from the word, checks it against the
// pointer bounds and alignment mask, and for a pointer looks up the word's own
// address in the region table (lowest valid slot with start <= address < end).
// A load writes the slot's start, end and valid bit and answers with all-zero
// fields; loads to slots at or beyond REGION_SLOTS are dropped. The block takes
// one beat every cycle while the response side does not stall: a beat is registered
// at the input, classified and looked up against all region slots in parallel,
// and lands in the response register. A load takes effect for every scan that
// follows it. Registers (csr_index): 0 minimum pointer, 1 maximum pointer, 2 tag
// value, 3 alignment mask; write them only while no beats are in flight.
module pointer_word_filter_core #(
   parameter int REGION_SLOTS = pwf_pkg::REGION_SLOTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [pwf_pkg::WORD_WIDTH-1:0]       req_word_address,
   input  logic [pwf_pkg::WORD_WIDTH-1:0]       req_word_value,
   input  logic [pwf_pkg::SLOT_WIDTH-1:0]       req_slot,
   input  logic [pwf_pkg::WORD_WIDTH-1:0]       req_slot_start,
   input  logic [pwf_pkg::WORD_WIDTH-1:0]       req_slot_end,
   input  logic                                 req_slot_enable,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_is_pointer,
   output logic [pwf_pkg::WORD_WIDTH-1:0]       rsp_pointer_value,
   output logic [pwf_pkg::WORD_WIDTH-1:0]       rsp_source_address,
   output logic                                 rsp_is_static,
   output logic [pwf_pkg::SLOT_WIDTH-1:0]       rsp_region_slot,
   output logic [pwf_pkg::WORD_WIDTH-1:0]       rsp_static_offset,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pwf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pwf_pkg::WORD_WIDTH-1:0]       csr_data
);
   import pwf_pkg::*;

   // only slot codes reachable through req_slot need storage
   localparam int TABLE_DEPTH = (REGION_SLOTS < SLOT_CODES) ? REGION_SLOTS : SLOT_CODES;

   filter_cfg_type cfg_ff;

   logic                  s1_valid_ff;
   logic                  s1_op_ff;
   logic [WORD_WIDTH-1:0] s1_address_ff;
   logic [WORD_WIDTH-1:0] s1_word_ff;
   logic [SLOT_WIDTH-1:0] s1_slot_ff;
   logic [WORD_WIDTH-1:0] s1_start_ff;
   logic [WORD_WIDTH-1:0] s1_limit_ff;
   logic                  s1_enable_ff;

   logic                  out_valid_ff;
   logic                  out_is_pointer_ff;
   logic [WORD_WIDTH-1:0] out_pointer_value_ff;
   logic [WORD_WIDTH-1:0] out_source_address_ff;
   logic                  out_is_static_ff;
   logic [SLOT_WIDTH-1:0] out_region_slot_ff;
   logic [WORD_WIDTH-1:0] out_static_offset_ff;

   logic                  out_is_pointer_in;
   logic [WORD_WIDTH-1:0] out_pointer_value_in;
   logic [WORD_WIDTH-1:0] out_source_address_in;
   logic                  out_is_static_in;
   logic [SLOT_WIDTH-1:0] out_region_slot_in;
   logic [WORD_WIDTH-1:0] out_static_offset_in;

   logic                  advance;
   logic                  req_take;
   logic                  is_pointer;
   logic [WORD_WIDTH-1:0] stripped;
   region_write_type      table_wr;
   region_hit_type        region;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pointer <= MIN_POINTER_RESET;
         cfg_ff.max_pointer <= MAX_POINTER_RESET;
         cfg_ff.tag_value <= TAG_VALUE_RESET;
         cfg_ff.align_mask <= ALIGN_MASK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_POINTER: cfg_ff.min_pointer <= csr_data;
            CSR_MAX_POINTER: cfg_ff.max_pointer <= csr_data;
            CSR_TAG_VALUE:   cfg_ff.tag_value <= csr_data[TAG_WIDTH-1:0];
            CSR_ALIGN_MASK:  cfg_ff.align_mask <= csr_data[MASK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // response register frees up when empty or when its beat leaves
   assign advance = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff <= req_op;
         s1_address_ff <= req_word_address;
         s1_word_ff <= req_word_value;
         s1_slot_ff <= req_slot;
         s1_start_ff <= req_slot_start;
         s1_limit_ff <= req_slot_end;
         s1_enable_ff <= req_slot_enable;
      end
   end

   pwf_classify u_classify (
      .cfg        (cfg_ff),
      .word_value (s1_word_ff),
      .is_pointer (is_pointer),
      .stripped   (stripped)
   );

   // a load writes the table as it leaves stage one, so the next scan sees it
   always_comb begin
      table_wr.en = s1_valid_ff && (s1_op_ff == OP_LOAD) && advance;
      table_wr.slot = s1_slot_ff;
      table_wr.start = s1_start_ff;
      table_wr.limit = s1_limit_ff;
      table_wr.enable = s1_enable_ff;
   end

   pwf_region_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_region_table (
      .clock          (clock),
      .reset          (reset),
      .wr             (table_wr),
      .lookup_address (s1_address_ff),
      .result         (region)
   );

   always_comb begin
      out_is_pointer_in = 1'b0;
      out_pointer_value_in = '0;
      out_source_address_in = '0;
      out_is_static_in = 1'b0;
      out_region_slot_in = '0;
      out_static_offset_in = '0;
      if (s1_op_ff == OP_SCAN) begin
         out_source_address_in = s1_address_ff;
         if (is_pointer) begin
            out_is_pointer_in = 1'b1;
            out_pointer_value_in = stripped;
            if (region.hit) begin
               out_is_static_in = 1'b1;
               out_region_slot_in = region.slot;
               out_static_offset_in = region.offset;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_is_pointer_ff <= out_is_pointer_in;
         out_pointer_value_ff <= out_pointer_value_in;
         out_source_address_ff <= out_source_address_in;
         out_is_static_ff <= out_is_static_in;
         out_region_slot_ff <= out_region_slot_in;
         out_static_offset_ff <= out_static_offset_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_is_pointer = out_is_pointer_ff;
   assign rsp_pointer_value = out_pointer_value_ff;
   assign rsp_source_address = out_source_address_ff;
   assign rsp_is_static = out_is_static_ff;
   assign rsp_region_slot = out_region_slot_ff;
   assign rsp_static_offset = out_static_offset_ff;

endmodule

// ===== tb/pointer_word_filter_core_tb.sv =====
module pointer_word_filter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pwf_pkg::*;

   localparam int N_SLOTS = REGION_SLOTS_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_PRINTED = 20;

   typedef struct packed {
      logic                  op;
      logic [WORD_WIDTH-1:0] addr;
      logic [WORD_WIDTH-1:0] word;
      logic [SLOT_WIDTH-1:0] slot;
      logic [WORD_WIDTH-1:0] start;
      logic [WORD_WIDTH-1:0] stop;
      logic                  enable;
   } req_beat_type;

   typedef struct packed {
      logic                  is_pointer;
      logic [WORD_WIDTH-1:0] pointer_value;
      logic [WORD_WIDTH-1:0] source_address;
      logic                  is_static;
      logic [SLOT_WIDTH-1:0] region_slot;
      logic [WORD_WIDTH-1:0] static_offset;
   } word_class_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_op;
   logic [WORD_WIDTH-1:0]      req_word_address;
   logic [WORD_WIDTH-1:0]      req_word_value;
   logic [SLOT_WIDTH-1:0]      req_slot;
   logic [WORD_WIDTH-1:0]      req_slot_start;
   logic [WORD_WIDTH-1:0]      req_slot_end;
   logic                       req_slot_enable;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_is_pointer;
   logic [WORD_WIDTH-1:0]      rsp_pointer_value;
   logic [WORD_WIDTH-1:0]      rsp_source_address;
   logic                       rsp_is_static;
   logic [SLOT_WIDTH-1:0]      rsp_region_slot;
   logic [WORD_WIDTH-1:0]      rsp_static_offset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [WORD_WIDTH-1:0]      csr_data;

   // shadow of the filter settings and region table
   logic [WORD_WIDTH-1:0] lo_bound;
   logic [WORD_WIDTH-1:0] hi_bound;
   logic [TAG_WIDTH-1:0]  tag_cfg;
   logic [MASK_WIDTH-1:0] mask_cfg;
   logic [WORD_WIDTH-1:0] tbl_start [N_SLOTS];
   logic [WORD_WIDTH-1:0] tbl_end [N_SLOTS];
   logic                  tbl_valid [N_SLOTS];

   word_class_type        pending_classes[$];
   logic [WORD_WIDTH-1:0] region_base;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;
   int errors = 0;
   int beats_sent = 0;
   int loads_sent = 0;
   int results_checked = 0;
   int pointers_seen = 0;
   int static_seen = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;

   pointer_word_filter_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_word_address   (req_word_address),
      .req_word_value     (req_word_value),
      .req_slot           (req_slot),
      .req_slot_start     (req_slot_start),
      .req_slot_end       (req_slot_end),
      .req_slot_enable    (req_slot_enable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_pointer     (rsp_is_pointer),
      .rsp_pointer_value  (rsp_pointer_value),
      .rsp_source_address (rsp_source_address),
      .rsp_is_static      (rsp_is_static),
      .rsp_region_slot    (rsp_region_slot),
      .rsp_static_offset  (rsp_static_offset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [WORD_WIDTH-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // classify one accepted beat; a load beat updates the region table
   function automatic word_class_type classify_word(req_beat_type b);
      word_class_type r;
      logic [WORD_WIDTH-1:0] v;
      int s;
      r = '0;
      if (b.op == OP_LOAD) begin
         if (b.slot < N_SLOTS) begin
            tbl_start[b.slot] = b.start;
            tbl_end[b.slot] = b.stop;
            tbl_valid[b.slot] = b.enable;
         end
         return r;
      end
      r.source_address = b.addr;
      v = (b.word[WORD_WIDTH-1:STRIP_WIDTH] == tag_cfg) ?
          {{TAG_WIDTH{1'b0}}, b.word[STRIP_WIDTH-1:0]} : b.word;
      if (v < lo_bound || v > hi_bound || (v & {61'b0, mask_cfg}) != '0)
         return r;
      r.is_pointer = 1'b1;
      r.pointer_value = v;
      for (s = 0; s < N_SLOTS && !r.is_static; s++) begin
         if (tbl_valid[s] && b.addr >= tbl_start[s] && b.addr < tbl_end[s]) begin
            r.is_static = 1'b1;
            r.region_slot = s[SLOT_WIDTH-1:0];
            r.static_offset = b.addr - tbl_start[s];
         end
      end
      return r;
   endfunction

   function automatic req_beat_type scan_beat(logic [WORD_WIDTH-1:0] addr,
                                              logic [WORD_WIDTH-1:0] word);
      req_beat_type b;
      b = '0;
      b.op = OP_SCAN;
      b.addr = addr;
      b.word = word;
      return b;
   endfunction

   function automatic req_beat_type load_beat(logic [SLOT_WIDTH-1:0] slot,
                                              logic [WORD_WIDTH-1:0] start,
                                              logic [WORD_WIDTH-1:0] stop, logic enable);
      req_beat_type b;
      b = '0;
      b.op = OP_LOAD;
      b.slot = slot;
      b.start = start;
      b.stop = stop;
      b.enable = enable;
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      logic [WORD_WIDTH-1:0] span;
      logic [WORD_WIDTH-1:0] off;
      logic [WORD_WIDTH-1:0] v;
      int pick;
      int k;
      b.op = ($urandom_range(99) < 15) ? OP_LOAD : OP_SCAN;
      b.addr = rand64();
      b.word = rand64();
      b.slot = SLOT_WIDTH'($urandom_range(N_SLOTS - 1));
      b.start = rand64();
      b.stop = rand64();
      b.enable = 1'($urandom_range(1));
      if (b.op == OP_LOAD) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            b.start = region_base + 64'($urandom_range(4095)) * 16;
            b.stop = b.start + 64'($urandom_range(1024));
         end else if (pick < 90) begin
            b.stop = b.start - 64'($urandom_range(8));
         end
         b.enable = ($urandom_range(99) < 85);
         return b;
      end
      // address mostly around the edges and inside of a table region
      pick = $urandom_range(99);
      k = $urandom_range(N_SLOTS - 1);
      span = (tbl_end[k] > tbl_start[k]) ? tbl_end[k] - tbl_start[k] : '0;
      if (pick < 40)
         b.addr = tbl_start[k] + 64'($urandom_range(1031)) - 4;
      else if (pick < 55)
         b.addr = tbl_end[k] + 64'($urandom_range(8)) - 4;
      else if (pick < 70 && span != '0)
         b.addr = tbl_start[k] + rand64() % span;
      else if (pick < 85)
         b.addr = region_base + 64'($urandom_range(65535));
      // word mostly a well-formed pointer for the current settings
      pick = $urandom_range(99);
      if (pick < 65 && lo_bound <= hi_bound) begin
         span = hi_bound - lo_bound;
         off = rand64();
         if (span != '1)
            off = off % (span + 1);
         if ($urandom_range(1))
            off = off % 4096;
         v = (lo_bound + off) & ~{61'b0, mask_cfg};
         b.word = (v[WORD_WIDTH-1:STRIP_WIDTH] == '0 && $urandom_range(1)) ?
                  {tag_cfg, v[STRIP_WIDTH-1:0]} : v;
      end else if (pick < 80) begin
         case ($urandom_range(3))
            0: v = lo_bound;
            1: v = hi_bound;
            2: v = lo_bound - 1;
            default: v = hi_bound + 1;
         endcase
         b.word = (v[WORD_WIDTH-1:STRIP_WIDTH] == '0 && $urandom_range(1)) ?
                  {tag_cfg, v[STRIP_WIDTH-1:0]} : v;
      end
      return b;
   endfunction

   // offer one beat at the falling edge and hold it until accepted
   task automatic send_beat(req_beat_type b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_op = b.op;
      req_word_address = b.addr;
      req_word_value = b.word;
      req_slot = b.slot;
      req_slot_start = b.start;
      req_slot_end = b.stop;
      req_slot_enable = b.enable;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_classes.insert(pending_classes.size(), classify_word(b));
      beats_sent++;
      if (b.op == OP_LOAD)
         loads_sent++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_classes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [WORD_WIDTH-1:0] data);
      @(negedge clock);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_MIN_POINTER: lo_bound = data;
         CSR_MAX_POINTER: hi_bound = data;
         CSR_TAG_VALUE: tag_cfg = data[TAG_WIDTH-1:0];
         CSR_ALIGN_MASK: mask_cfg = data[MASK_WIDTH-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_filter(logic [WORD_WIDTH-1:0] lo, logic [WORD_WIDTH-1:0] hi,
                             logic [TAG_WIDTH-1:0] tag, logic [MASK_WIDTH-1:0] mask);
      write_csr(CSR_MIN_POINTER, lo);
      write_csr(CSR_MAX_POINTER, hi);
      write_csr(CSR_TAG_VALUE, {48'b0, tag});
      write_csr(CSR_ALIGN_MASK, {61'b0, mask});
   endtask

   task automatic report_mismatch(string field, logic [WORD_WIDTH-1:0] got,
                                  logic [WORD_WIDTH-1:0] want);
      if (errors < MAX_PRINTED)
         $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      word_class_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_classes.size() == 0) begin
            report_mismatch("unexpected beat", rsp_source_address, '0);
         end else begin
            want = pending_classes.pop_front();
            results_checked++;
            if (want.is_pointer)
               pointers_seen++;
            if (want.is_static)
               static_seen++;
            if (rsp_is_pointer !== want.is_pointer)
               report_mismatch("is_pointer", 64'(rsp_is_pointer), 64'(want.is_pointer));
            if (rsp_pointer_value !== want.pointer_value)
               report_mismatch("pointer_value", rsp_pointer_value, want.pointer_value);
            if (rsp_source_address !== want.source_address)
               report_mismatch("source_address", rsp_source_address, want.source_address);
            if (rsp_is_static !== want.is_static)
               report_mismatch("is_static", 64'(rsp_is_static), 64'(want.is_static));
            if (rsp_region_slot !== want.region_slot)
               report_mismatch("region_slot", 64'(rsp_region_slot), 64'(want.region_slot));
            if (rsp_static_offset !== want.static_offset)
               report_mismatch("static_offset", rsp_static_offset, want.static_offset);
         end
      end
   end

   // receiver: long hold-off when asked, otherwise random stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("** pointer_word_filter_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed_cases();
      logic [WORD_WIDTH-1:0] ptr;
      ptr = 64'hB400_0050_0000_0000;
      send_beat(load_beat(3'd0, 64'h1000, 64'h2000, 1'b1));
      send_beat(load_beat(3'd1, 64'h1800, 64'h3000, 1'b1));
      send_beat(load_beat(3'd7, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
      send_beat(load_beat(3'd2, 64'h5000, 64'h5000, 1'b1));
      send_beat(load_beat(3'd3, 64'h7000, 64'h6000, 1'b1));
      send_beat(load_beat(3'd4, 64'h8000, 64'h9000, 1'b0));
      send_beat(scan_beat(64'h1000, ptr));
      // overlap resolves to the lowest slot
      send_beat(scan_beat(64'h1900, ptr));
      send_beat(scan_beat(64'h2000, ptr));
      send_beat(scan_beat(64'h3000, ptr));
      send_beat(scan_beat(64'h5000, ptr));
      send_beat(scan_beat(64'h6800, ptr));
      send_beat(scan_beat(64'h8800, ptr));
      send_beat(scan_beat(64'hFFFF_FFFF_FFFF_FFF8, ptr));
      send_beat(scan_beat(64'hFFFF_FFFF_FFFF_FFFF, ptr));
      send_beat(scan_beat(64'h1010, 64'h0));
      send_beat(scan_beat(64'h1010, 64'hFFFF_FFFF_FFFF_FFFF));
      send_beat(scan_beat(64'h1010, MIN_POINTER_RESET));
      send_beat(scan_beat(64'h1010, 64'h0000_007F_FFFF_FFFC));
      send_beat(scan_beat(64'h1010, MAX_POINTER_RESET));
      send_beat(scan_beat(64'h1010, 64'h0000_0044_FFFF_FFFC));
      send_beat(scan_beat(64'h1010, 64'h0000_0080_0000_0000));
      send_beat(scan_beat(64'h1010, 64'hB400_0060_0000_0002));
      send_beat(scan_beat(64'h1010, 64'hB401_0060_0000_0000));
      send_beat(load_beat(3'd0, 64'h1000, 64'h2000, 1'b0));
      send_beat(scan_beat(64'h1900, ptr));
      wait_drain();
   endtask

   task automatic test_bound_extremes();
      set_filter('0, '1, 16'h0000, 3'd0);
      send_beat(scan_beat(64'h1900, 64'h0));
      send_beat(scan_beat(64'h2FFF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_beat(scan_beat(64'h0, 64'h0000_1234_5678_9ABF));
      wait_drain();
      set_filter('0, '1, 16'hFFFF, 3'd7);
      send_beat(scan_beat(64'h1800, 64'hFFFF_FFFF_FFFF_FFFF));
      send_beat(scan_beat(64'h1800, 64'hFFFF_0000_0000_0008));
      send_beat(scan_beat(64'h1800, 64'hFFFE_0000_0000_0010));
      wait_drain();
      // min above max: nothing passes
      set_filter(64'h100, 64'hFF, 16'h0000, 3'd0);
      send_beat(scan_beat(64'h1800, 64'h100));
      send_beat(scan_beat(64'h1800, 64'hFF));
      wait_drain();
   endtask

   task automatic run_phase(int count, int s_pct, int r_pct, logic [WORD_WIDTH-1:0] base);
      int i;
      send_idle_pct = s_pct;
      rsp_idle_pct = r_pct;
      region_base = base;
      for (i = 0; i < N_SLOTS; i++)
         send_beat(load_beat(i[SLOT_WIDTH-1:0], base + 64'(i) * 64'h4000,
                             base + 64'(i) * 64'h4000 + 64'($urandom_range(1, 8192)), 1'b1));
      for (i = N_SLOTS; i < count; i++)
         send_beat(random_beat());
      wait_drain();
   endtask

   task automatic test_random_traffic();
      logic [WORD_WIDTH-1:0] lo;
      set_filter(MIN_POINTER_RESET, MAX_POINTER_RESET, TAG_VALUE_RESET, ALIGN_MASK_RESET);
      run_phase(370, 19, 68, rand64() & ~64'hF_FFFF);
      lo = rand64() >> 24;
      set_filter(lo, lo + 64'($urandom) * 64'h100, 16'($urandom), 3'($urandom));
      run_phase(370, 68, 19, rand64() & ~64'hF_FFFF);
      lo = rand64();
      set_filter(lo, lo + rand64() % 64'h1_0000_0000, 16'($urandom), 3'd7);
      // regions near the top of the address space, some wrap past zero
      run_phase(370, 0, 0, 64'hFFFF_FFFF_FFFF_0000);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
   endtask

   task automatic test_output_backpressure();
      int i;
      set_filter('0, '1, 16'hB400, 3'd0);
      @(negedge clock);
      hold_left = 150;
      // keep offering while the response side is held off
      for (i = 0; i < 40; i++)
         send_beat(random_beat());
      wait_drain();
   endtask

   initial begin
      int s;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_SCAN;
      req_word_address = '0;
      req_word_value = '0;
      req_slot = '0;
      req_slot_start = '0;
      req_slot_end = '0;
      req_slot_enable = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_MIN_POINTER;
      csr_data = '0;
      lo_bound = MIN_POINTER_RESET;
      hi_bound = MAX_POINTER_RESET;
      tag_cfg = TAG_VALUE_RESET;
      mask_cfg = ALIGN_MASK_RESET;
      for (s = 0; s < N_SLOTS; s++) begin
         tbl_start[s] = '0;
         tbl_end[s] = '0;
         tbl_valid[s] = 1'b0;
      end
      region_base = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_bound_extremes();
      test_random_traffic();
      test_output_backpressure();

      wait_drain();
      repeat (10) @(posedge clock);
      $display("covered %0d request beats (%0d region loads) and %0d register writes",
               beats_sent, loads_sent, csr_writes);
      $display("checked %0d responses: %0d pointers, %0d inside static regions, %0d errors",
               results_checked, pointers_seen, static_seen, errors);
      if (errors == 0 && pending_classes.size() == 0)
         $display("** pointer_word_filter_core: PASSED **");
      else
         $display("** pointer_word_filter_core: FAILED **");
      $finish;
   end

endmodule
